[rtl/ams_pkg.sv]
// Shared types, constants and helper functions of the accumulator machine.
package ams_pkg;

    localparam int MEM_WORDS = 256;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(MEM_WORDS);
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
    localparam int IO_BITS   = 32;

    localparam logic [7:0] HALT_MARKER = 8'd99;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef addr_t addr_table_t [256];

    typedef enum logic [7:0] {
        OP_ADD   = 8'd1,
        OP_SUB   = 8'd2,
        OP_MUL   = 8'd3,
        OP_DIV   = 8'd4,
        OP_LOAD  = 8'd5,
        OP_LDI   = 8'd6,
        OP_STORE = 8'd7,
        OP_INPUT = 8'd8,
        OP_OUT   = 8'd9,
        OP_HALT  = 8'd10,
        OP_JMP   = 8'd11,
        OP_JZ    = 8'd12,
        OP_JNZ   = 8'd13,
        OP_JLT   = 8'd14,
        OP_JLE   = 8'd15,
        OP_JGT   = 8'd16,
        OP_JGE   = 8'd17
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_RUN      = 2'd0,
        STAT_HALT_OK  = 2'd1,
        STAT_HALT_BAD = 2'd2,
        STAT_DIV_ZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_ADD,
        AL_MUL,
        AL_NEGA,
        AL_NEGB,
        AL_DIV,
        AL_NEGQ,
        AL_DONE
    } alu_state_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_ALU,
        SQ_DONE
    } seq_state_t;

    // Operand addresses wrap modulo the memory depth.
    function automatic addr_table_t build_addr_table();
        addr_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = ADDR_BITS'(i % MEM_WORDS);
        end
        return t;
    endfunction

    localparam addr_table_t ADDR_TABLE = build_addr_table();

    function automatic word_t io_to_word(logic signed [IO_BITS-1:0] v);
        return WORD_BITS'(v);
    endfunction

    function automatic logic [IO_BITS-1:0] word_to_io(word_t w);
        return IO_BITS'(signed'(w));
    endfunction

endpackage

[rtl/accumulator_machine_step.sv]
// Accumulator machine: executes one fetched instruction per input transfer.
// Add, subtract, multiply and a divide by a nonzero word run in the iterative arithmetic
// unit. One instruction is in work at a time, so the next input transfer waits until the
// result has been loaded into the output register, which a result stall can hold off.
// Reset clears the accumulator, program counter, halt flags and memory valid bits.
module accumulator_machine_step
    import ams_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          mode,
    input  logic [7:0]          operand,
    input  logic signed [31:0]  input_word,
    output logic                res_valid,
    input  logic                res_stall,
    output logic signed [31:0]  accumulator,
    output logic [7:0]          next_pc,
    output logic                out_valid,
    output logic signed [31:0]  out_word,
    output logic [1:0]          status
);

    seq_state_t             state_reg, state_next;
    word_t                  acc_reg, acc_next;
    logic [7:0]             pc_reg, pc_next;
    logic                   halted_reg, halted_next;
    logic                   halt_ok_reg, halt_ok_next;
    logic [MEM_WORDS-1:0]   vld_reg;

    logic [7:0]             mode_reg;
    logic [7:0]             opnd_reg;
    addr_t                  addr_reg;
    logic [IO_BITS-1:0]     iw_reg;

    word_t                  mem [MEM_WORDS];
    word_t                  rd_data_reg;
    logic                   rd_vld_reg;

    logic                   pend_ov_reg, pend_ov_next;
    logic [IO_BITS-1:0]     pend_ow_reg, pend_ow_next;
    status_t                pend_st_reg, pend_st_next;

    logic                   res_valid_reg;
    logic [IO_BITS-1:0]     res_acc_reg;
    logic [7:0]             res_pc_reg;
    logic                   res_ov_reg;
    logic [IO_BITS-1:0]     res_ow_reg;
    status_t                res_st_reg;

    logic                   in_xfer;
    logic                   res_load;
    addr_t                  in_addr;
    word_t                  m_word;
    logic                   acc_zero;
    logic                   acc_neg;
    logic                   jump;
    logic                   mem_we;
    word_t                  mem_wdata;
    alu_req_t               alu_req;
    logic                   alu_done;
    word_t                  alu_result;

    assign in_stall = (state_reg != SQ_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign in_addr  = ADDR_TABLE[operand];
    assign res_load = (state_reg == SQ_DONE) && (!res_valid_reg || !res_stall);

    assign m_word   = (addr_reg == '0) ? acc_reg : (rd_vld_reg ? rd_data_reg : '0);
    assign acc_zero = (acc_reg == '0);
    assign acc_neg  = acc_reg[WORD_BITS-1];

    ams_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (acc_reg),
        .b      (m_word),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = SQ_EXEC;
                end
            end
            SQ_EXEC:
            begin
                state_next = alu_req.start ? SQ_ALU : SQ_DONE;
            end
            SQ_ALU:
            begin
                if (alu_done)
                begin
                    state_next = SQ_DONE;
                end
            end
            default:
            begin
                if (res_load)
                begin
                    state_next = SQ_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        acc_next      = acc_reg;
        pc_next       = pc_reg;
        halted_next   = halted_reg;
        halt_ok_next  = halt_ok_reg;
        pend_ov_next  = pend_ov_reg;
        pend_ow_next  = pend_ow_reg;
        pend_st_next  = pend_st_reg;
        mem_we        = 1'b0;
        mem_wdata     = acc_reg;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        jump          = 1'b0;
        unique case (state_reg)
            SQ_EXEC:
            begin
                pend_ov_next = 1'b0;
                pend_ow_next = '0;
                pend_st_next = STAT_RUN;
                if (halted_reg)
                begin
                    pend_st_next = halt_ok_reg ? STAT_HALT_OK : STAT_HALT_BAD;
                end
                else
                begin
                    pc_next = pc_reg + 8'd1;
                    unique case (mode_reg)
                        OP_ADD:
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_ADD;
                        end
                        OP_SUB:
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_SUB;
                        end
                        OP_MUL:
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_MUL;
                        end
                        OP_DIV:
                        begin
                            if (m_word == '0)
                            begin
                                pend_st_next = STAT_DIV_ZERO;
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                alu_req.op    = ALU_DIV;
                            end
                        end
                        OP_LOAD:
                        begin
                            acc_next = m_word;
                        end
                        OP_LDI:
                        begin
                            acc_next = WORD_BITS'(opnd_reg);
                        end
                        OP_STORE:
                        begin
                            mem_we = (addr_reg != '0);
                        end
                        OP_INPUT:
                        begin
                            mem_wdata = io_to_word(iw_reg);
                            if (addr_reg == '0)
                            begin
                                acc_next = mem_wdata;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                            end
                        end
                        OP_OUT:
                        begin
                            pend_ov_next = 1'b1;
                            pend_ow_next = word_to_io(m_word);
                        end
                        OP_HALT:
                        begin
                            halted_next  = 1'b1;
                            halt_ok_next = (opnd_reg == HALT_MARKER);
                            pend_st_next = (opnd_reg == HALT_MARKER) ?
                                           STAT_HALT_OK : STAT_HALT_BAD;
                            pc_next      = pc_reg;
                        end
                        OP_JMP:  jump = 1'b1;
                        OP_JZ:   jump = acc_zero;
                        OP_JNZ:  jump = !acc_zero;
                        OP_JLT:  jump = acc_neg;
                        OP_JLE:  jump = acc_neg || acc_zero;
                        OP_JGT:  jump = !acc_neg && !acc_zero;
                        OP_JGE:  jump = !acc_neg;
                        default: jump = 1'b0;
                    endcase
                    if (jump)
                    begin
                        pc_next = opnd_reg - 8'd1;
                    end
                end
            end
            SQ_ALU:
            begin
                if (alu_done)
                begin
                    acc_next = alu_result;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            acc_reg       <= '0;
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            halt_ok_reg   <= 1'b0;
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            pc_reg      <= pc_next;
            halted_reg  <= halted_next;
            halt_ok_reg <= halt_ok_next;
            if (mem_we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        if (in_xfer)
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg   <= mode;
            opnd_reg   <= operand;
            addr_reg   <= in_addr;
            iw_reg     <= input_word;
            rd_vld_reg <= vld_reg[in_addr];
        end
        pend_ov_reg <= pend_ov_next;
        pend_ow_reg <= pend_ow_next;
        pend_st_reg <= pend_st_next;
        if (res_load)
        begin
            res_acc_reg <= word_to_io(acc_reg);
            res_pc_reg  <= pc_reg;
            res_ov_reg  <= pend_ov_reg;
            res_ow_reg  <= pend_ow_reg;
            res_st_reg  <= pend_st_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign accumulator = res_acc_reg;
    assign next_pc     = res_pc_reg;
    assign out_valid   = res_ov_reg;
    assign out_word    = res_ow_reg;
    assign status      = res_st_reg;

`ifndef SYNTHESIS
    a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_EXEC) && halted_reg |=> pc_reg == $past(pc_reg))
        else $error("program counter moved after halt");

    a_alu_start_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> state_reg == SQ_EXEC)
        else $error("arithmetic unit started outside execute");

    a_div_zero_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_EXEC) && !halted_reg && (mode_reg == OP_DIV) && (m_word == '0)
        |=> acc_reg == $past(acc_reg))
        else $error("accumulator changed on divide by zero");
`endif

endmodule

[rtl/ams_alu.sv]
// Iterative arithmetic unit: add, subtract, shift-add multiply and restoring divide.
module ams_alu
    import ams_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    input  word_t    a,
    input  word_t    b,
    output logic     done,
    output word_t    result
);

    alu_state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    alu_op_t               op_reg, op_next;
    logic                  neg_reg, neg_next;
    word_t                 x_reg, x_next;
    word_t                 y_reg, y_next;
    word_t                 p_reg, p_next;

    logic [WORD_BITS:0]    ax;
    logic [WORD_BITS:0]    ay;
    logic                  cin;
    logic [WORD_BITS+1:0]  sum;
    logic                  carry;
    logic                  last;

    assign sum   = {1'b0, ax} + {1'b0, ay} + {{(WORD_BITS+1){1'b0}}, cin};
    assign carry = sum[WORD_BITS+1];
    assign last  = (cnt_reg == CNT_BITS'(1));

    always_comb
    begin
        ax  = '0;
        ay  = '0;
        cin = 1'b0;
        unique case (state_reg)
            AL_ADD:
            begin
                ax  = {1'b0, x_reg};
                ay  = (op_reg == ALU_SUB) ? {1'b0, ~y_reg} : {1'b0, y_reg};
                cin = (op_reg == ALU_SUB);
            end
            AL_MUL:
            begin
                ax = {1'b0, p_reg};
                ay = {1'b0, x_reg};
            end
            AL_NEGA:
            begin
                ay  = {1'b0, ~x_reg};
                cin = 1'b1;
            end
            AL_NEGB:
            begin
                ay  = {1'b0, ~y_reg};
                cin = 1'b1;
            end
            AL_DIV:
            begin
                ax  = {p_reg, x_reg[WORD_BITS-1]};
                ay  = ~{1'b0, y_reg};
                cin = 1'b1;
            end
            AL_NEGQ:
            begin
                ay  = neg_reg ? {1'b0, ~x_reg} : {1'b0, x_reg};
                cin = neg_reg;
            end
            default:
            begin
                ax  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AL_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        ALU_ADD, ALU_SUB: state_next = AL_ADD;
                        ALU_MUL:          state_next = AL_MUL;
                        default:          state_next = AL_NEGA;
                    endcase
                end
            end
            AL_ADD:  state_next = AL_DONE;
            AL_MUL:  state_next = last ? AL_DONE : AL_MUL;
            AL_NEGA: state_next = AL_NEGB;
            AL_NEGB: state_next = AL_DIV;
            AL_DIV:  state_next = last ? AL_NEGQ : AL_DIV;
            AL_NEGQ: state_next = AL_DONE;
            default: state_next = AL_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        op_next  = op_reg;
        neg_next = neg_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        p_next   = p_reg;
        unique case (state_reg)
            AL_IDLE:
            begin
                if (req.start)
                begin
                    x_next   = a;
                    y_next   = b;
                    p_next   = '0;
                    cnt_next = CNT_BITS'(WORD_BITS);
                    op_next  = req.op;
                    neg_next = a[WORD_BITS-1] ^ b[WORD_BITS-1];
                end
            end
            AL_ADD:
            begin
                p_next = sum[WORD_BITS-1:0];
            end
            AL_MUL:
            begin
                if (y_reg[0])
                begin
                    p_next = sum[WORD_BITS-1:0];
                end
                x_next   = {x_reg[WORD_BITS-2:0], 1'b0};
                y_next   = {1'b0, y_reg[WORD_BITS-1:1]};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            AL_NEGA:
            begin
                if (x_reg[WORD_BITS-1])
                begin
                    x_next = sum[WORD_BITS-1:0];
                end
            end
            AL_NEGB:
            begin
                if (y_reg[WORD_BITS-1])
                begin
                    y_next = sum[WORD_BITS-1:0];
                end
            end
            AL_DIV:
            begin
                p_next   = carry ? sum[WORD_BITS-1:0] : ax[WORD_BITS-1:0];
                x_next   = {x_reg[WORD_BITS-2:0], carry};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            AL_NEGQ:
            begin
                p_next = sum[WORD_BITS-1:0];
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AL_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        p_reg   <= p_next;
    end

    assign done   = (state_reg == AL_DONE);
    assign result = p_reg;

endmodule

[sim/machine_step_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts every result of the accumulator machine and compares it on transfer.
module machine_step_checker
    import ams_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [7:0]          mode,
    input  logic [7:0]          operand,
    input  logic signed [31:0]  input_word,
    input  logic                res_valid,
    input  logic                res_stall,
    input  logic signed [31:0]  accumulator,
    input  logic [7:0]          next_pc,
    input  logic                out_valid,
    input  logic signed [31:0]  out_word,
    input  logic [1:0]          status,
    output int                  mismatch_count,
    output int                  pending
);

    typedef struct packed {
        logic [31:0] acc;
        logic [7:0]  pc;
        logic        ov;
        logic [31:0] ow;
        status_t     st;
    } step_result_t;

    logic [31:0]  data_mem [256];
    logic [7:0]   pc_q;
    logic         halted_q;
    logic         halt_ok_q;
    step_result_t expected_results [$];
    step_result_t oldest;

    function automatic step_result_t execute_instruction(input logic [7:0] op,
                                                         input logic [7:0] opnd,
                                                         input logic [31:0] iw);
        step_result_t       r;
        logic [31:0]        acc;
        logic [31:0]        m;
        logic signed [31:0] acc_s;
        logic signed [31:0] m_s;
        logic [7:0]         nxt;
        logic               take_jump;
        logic               neg;
        logic               zero;
        r = '0;
        acc = data_mem[0];
        m = data_mem[opnd];
        acc_s = acc;
        m_s = m;
        neg = acc[31];
        zero = (acc == 32'd0);
        nxt = pc_q + 8'd1;
        take_jump = 1'b0;
        if (halted_q)
        begin
            r.acc = acc;
            r.pc = pc_q;
            r.st = halt_ok_q ? STAT_HALT_OK : STAT_HALT_BAD;
            return r;
        end
        r.st = STAT_RUN;
        case (op)
            OP_ADD:   data_mem[0] = acc + m;
            OP_SUB:   data_mem[0] = acc - m;
            OP_MUL:   data_mem[0] = acc * m;
            OP_DIV:
            begin
                if (m == 32'd0)
                    r.st = STAT_DIV_ZERO;
                else if (acc == 32'h8000_0000 && m == 32'hFFFF_FFFF)
                    data_mem[0] = acc;
                else
                    data_mem[0] = acc_s / m_s;
            end
            OP_LOAD:  data_mem[0] = m;
            OP_LDI:   data_mem[0] = {24'd0, opnd};
            OP_STORE: data_mem[opnd] = acc;
            OP_INPUT: data_mem[opnd] = iw;
            OP_OUT:
            begin
                r.ov = 1'b1;
                r.ow = m;
            end
            OP_HALT:
            begin
                halted_q = 1'b1;
                halt_ok_q = (opnd == HALT_MARKER);
                r.st = halt_ok_q ? STAT_HALT_OK : STAT_HALT_BAD;
                nxt = pc_q;
            end
            OP_JMP:   take_jump = 1'b1;
            OP_JZ:    take_jump = zero;
            OP_JNZ:   take_jump = !zero;
            OP_JLT:   take_jump = neg;
            OP_JLE:   take_jump = neg || zero;
            OP_JGT:   take_jump = !neg && !zero;
            OP_JGE:   take_jump = !neg;
            default:  ;
        endcase
        if (take_jump)
            nxt = opnd - 8'd1;
        pc_q = nxt;
        r.acc = data_mem[0];
        r.pc = nxt;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 256; k++)
            begin
                data_mem[k] = 32'd0;
            end
            pc_q = 8'd0;
            halted_q = 1'b0;
            halt_ok_q = 1'b0;
            expected_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(execute_instruction(mode, operand, input_word));
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with no result expected", $time);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (accumulator !== oldest.acc)
                    begin
                        $display("%0t: accumulator expected %0d, actual %0d", $time,
                                 $signed(oldest.acc), accumulator);
                        mismatch_count++;
                    end
                    if (next_pc !== oldest.pc)
                    begin
                        $display("%0t: next_pc expected %0d, actual %0d", $time,
                                 oldest.pc, next_pc);
                        mismatch_count++;
                    end
                    if (out_valid !== oldest.ov)
                    begin
                        $display("%0t: out_valid expected %0d, actual %0d", $time,
                                 oldest.ov, out_valid);
                        mismatch_count++;
                    end
                    if (out_word !== oldest.ow)
                    begin
                        $display("%0t: out_word expected %0d, actual %0d", $time,
                                 $signed(oldest.ow), out_word);
                        mismatch_count++;
                    end
                    if (status !== oldest.st)
                    begin
                        $display("%0t: status expected %0d, actual %0d", $time,
                                 oldest.st, status);
                        mismatch_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

[sim/tb_accumulator_machine_step.sv]
`timescale 1ns / 1ps
// Top of the accumulator machine testbench: clock, reset, instruction stimulus and verdict.
module tb_accumulator_machine_step
    import ams_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         mode;
    logic [7:0]         operand;
    logic signed [31:0] input_word;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic signed [31:0] accumulator;
    logic [7:0]         next_pc;
    logic               out_valid;
    logic signed [31:0] out_word;
    logic [1:0]         status;

    int mismatch_count;
    int pending;
    int cycle_count = 0;
    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int rx_wait = 0;
    int rx_draw;

    accumulator_machine_step dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .operand    (operand),
        .input_word (input_word),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .accumulator(accumulator),
        .next_pc    (next_pc),
        .out_valid  (out_valid),
        .out_word   (out_word),
        .status     (status)
    );

    machine_step_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .operand       (operand),
        .input_word    (input_word),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .accumulator   (accumulator),
        .next_pc       (next_pc),
        .out_valid     (out_valid),
        .out_word      (out_word),
        .status        (status),
        .mismatch_count(mismatch_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // After each result transfer the receiver stalls for a freshly drawn number of cycles.
    always @(posedge clk)
    begin
        if (rx_wait != 0)
        begin
            res_stall <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
        else if (res_valid && !res_stall)
        begin
            rx_draw = $urandom_range(0, rx_gap_max);
            res_stall <= (rx_draw != 0);
            rx_wait <= (rx_draw == 0) ? 0 : rx_draw - 1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    task automatic send_instr(input logic [7:0] m, input logic [7:0] opnd,
                              input logic [31:0] w);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        operand <= opnd;
        input_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0]  mode_v;
        logic [7:0]  opnd_v;
        logic [31:0] word_v;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= 8'd0;
        operand <= 8'd0;
        input_word <= 32'sd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gap_max = 4;
        rx_gap_max = 4;
        send_instr(OP_LDI, 8'd255, 32'd0);
        send_instr(OP_INPUT, 8'd1, 32'h7FFF_FFFF);
        send_instr(OP_ADD, 8'd1, 32'd0);
        send_instr(OP_INPUT, 8'd2, 32'h8000_0000);
        send_instr(OP_SUB, 8'd2, 32'd0);
        send_instr(OP_MUL, 8'd1, 32'd0);
        send_instr(OP_INPUT, 8'd0, 32'h8000_0000);
        send_instr(OP_INPUT, 8'd3, 32'hFFFF_FFFF);
        send_instr(OP_DIV, 8'd3, 32'd0);
        send_instr(OP_DIV, 8'd4, 32'd0);
        send_instr(OP_LDI, 8'd7, 32'd0);
        send_instr(OP_INPUT, 8'd5, 32'hFFFF_FFFE);
        send_instr(OP_DIV, 8'd5, 32'd0);
        send_instr(OP_STORE, 8'd200, 32'd0);
        send_instr(OP_LOAD, 8'd200, 32'd0);
        send_instr(OP_OUT, 8'd2, 32'd0);
        send_instr(OP_JLT, 8'd40, 32'd0);
        send_instr(OP_JGE, 8'd50, 32'd0);
        send_instr(OP_JLE, 8'd30, 32'd0);
        send_instr(8'd0, 8'd170, 32'd0);
        send_instr(8'd255, 8'd85, 32'd0);
        send_instr(OP_LDI, 8'd0, 32'd0);
        send_instr(OP_JZ, 8'd0, 32'd0);
        send_instr(OP_JNZ, 8'd9, 32'd0);
        send_instr(OP_JGT, 8'd5, 32'd0);
        send_instr(OP_JGE, 8'd255, 32'd0);
        send_instr(OP_JMP, 8'd128, 32'd0);

        // Hold the sender back until the machine has answered every instruction.
        wait_for_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        tx_gap_max = 0;
                        rx_gap_max = 0;
                    end
                    1:
                    begin
                        tx_gap_max = 12;
                        rx_gap_max = 12;
                    end
                    2:
                    begin
                        tx_gap_max = 0;
                        rx_gap_max = 12;
                    end
                    default:
                    begin
                        tx_gap_max = 12;
                        rx_gap_max = 0;
                    end
                endcase
            end
            if ($urandom_range(0, 99) < 4)
                mode_v = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(18, 255));
            else
            begin
                mode_v = 8'($urandom_range(1, 17));
                if (mode_v == OP_HALT)
                    mode_v = OP_INPUT;
            end
            if ($urandom_range(0, 3) != 0)
                opnd_v = 8'($urandom_range(0, 7));
            else
                opnd_v = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0:       word_v = 32'h8000_0000;
                1:       word_v = 32'h7FFF_FFFF;
                2:       word_v = 32'hFFFF_FFFF;
                3:       word_v = 32'd0;
                4:       word_v = 32'd1;
                default: word_v = $urandom();
            endcase
            send_instr(mode_v, opnd_v, word_v);
        end

        // The machine halts for good, so the halt and what follows it come last.
        tx_gap_max = 4;
        rx_gap_max = 4;
        opnd_v = ($urandom_range(0, 1) != 0) ? HALT_MARKER : 8'($urandom_range(0, 255));
        send_instr(OP_HALT, opnd_v, 32'd0);
        send_instr(OP_LDI, 8'd77, 32'd0);
        send_instr(OP_OUT, 8'd0, 32'd0);
        send_instr(OP_HALT, HALT_MARKER, 32'd0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
